// ===== sv/ffr_pkg.sv =====
// ----------------------------------------------------------------------------
// ffr_pkg
// Shared types and constants of the fragmented frame receiver.
// ----------------------------------------------------------------------------
package ffr_pkg;

  localparam logic [7:0] START_BYTE  = 8'h01;
  localparam logic [7:0] END_BYTE    = 8'h04;
  localparam logic [8:0] PAYLOAD_POS = 9'd7;

  // header byte positions inside a frame
  localparam logic [8:0] POS_FLEN    = 9'd1;
  localparam logic [8:0] POS_MLEN_HI = 9'd2;
  localparam logic [8:0] POS_MLEN_LO = 9'd3;
  localparam logic [8:0] POS_CMD     = 9'd4;
  localparam logic [8:0] POS_OFF_HI  = 9'd5;
  localparam logic [8:0] POS_OFF_LO  = 9'd6;

  localparam int unsigned ResultW = 45;
  localparam int unsigned ResultBytesW = 48;

  typedef enum logic [2:0] {
    EV_CONSUMED = 3'd0,
    EV_IGNORED  = 3'd1,
    EV_PAYLOAD  = 3'd2,
    EV_DONE     = 3'd3,
    EV_FRAGMENT = 3'd4,
    EV_ERROR    = 3'd5
  } ffr_event_e;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_END    = 4'b1000
  } ffr_phase_e;

  // packed from the lowest bit up: event, payload byte, index, command, length
  typedef struct packed {
    logic [15:0] message_length;
    logic [7:0]  command_code;
    logic [9:0]  payload_index;
    logic [7:0]  payload_byte;
    ffr_event_e  event_res;
  } ffr_result_t;

endpackage

// ===== sv/ffr_parser.sv =====
// ----------------------------------------------------------------------------
// ffr_parser
// Frame parse state and message reassembly state, updated once per byte.
// ----------------------------------------------------------------------------
module ffr_parser #(
  parameter int unsigned BufferDepth = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          invalid_cmd_i,
  output ffr_pkg::ffr_result_t result_o
);
  import ffr_pkg::*;

  localparam int unsigned CntW = $clog2(BufferDepth + 1);

  ffr_phase_e      phase_q, phase_d;
  logic [8:0]      pos_q, pos_d;
  logic [7:0]      flen_q, flen_d;
  logic [7:0]      hlen_hi_q, hlen_hi_d;
  logic [7:0]      hlen_lo_q, hlen_lo_d;
  logic [7:0]      hcmd_q, hcmd_d;
  logic [7:0]      hoff_hi_q, hoff_hi_d;
  logic [15:0]     alen_q, alen_d;
  logic [7:0]      acmd_q, acmd_d;
  logic [15:0]     roff_q, roff_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [15:0]      hlen;
  logic [15:0]      hoff;
  logic [7:0]       plen;
  logic [16:0]      frag_end;
  logic             hdr_ok;
  logic             ok;
  logic [CntW+9:0]  cnt_ext;
  ffr_result_t      res;

  always_comb begin
    hlen     = {hlen_hi_q, hlen_lo_q};
    hoff     = {hoff_hi_q, byte_i};
    plen     = flen_q - 8'(PAYLOAD_POS - 9'd1);
    frag_end = {1'b0, hoff} + {9'b0, plen};
    hdr_ok   = ({1'b0, flen_q} >= PAYLOAD_POS) && (hlen != 16'd0) &&
               (hcmd_q != invalid_cmd_i) && (frag_end <= {1'b0, hlen});
    if (alen_q != 16'd0) begin
      hdr_ok = hdr_ok && (alen_q == hlen) && (acmd_q == hcmd_q) && (roff_q == hoff);
    end
    cnt_ext = {10'b0, cnt_q};
  end

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    flen_d    = flen_q;
    hlen_hi_d = hlen_hi_q;
    hlen_lo_d = hlen_lo_q;
    hcmd_d    = hcmd_q;
    hoff_hi_d = hoff_hi_q;
    alen_d    = alen_q;
    acmd_d    = acmd_q;
    roff_d    = roff_q;
    cnt_d     = cnt_q;
    ok        = 1'b1;
    res       = '0;
    res.event_res = EV_CONSUMED;

    case (phase_q)
      PH_HUNT: begin
        if (byte_i == START_BYTE) begin
          phase_d = PH_HEADER;
          pos_d   = POS_FLEN;
        end else begin
          res.event_res = EV_IGNORED;
        end
      end
      PH_HEADER: begin
        case (pos_q)
          POS_FLEN:    flen_d    = byte_i;
          POS_MLEN_HI: hlen_hi_d = byte_i;
          POS_MLEN_LO: hlen_lo_d = byte_i;
          POS_CMD:     hcmd_d    = byte_i;
          POS_OFF_HI:  hoff_hi_d = byte_i;
          POS_OFF_LO: begin
            if (hdr_ok) begin
              phase_d = PH_DATA;
              // first fragment opens the message
              if (alen_q == 16'd0) begin
                alen_d = hlen;
                acmd_d = hcmd_q;
              end
            end else begin
              ok = 1'b0;
            end
          end
          default: ok = 1'b0;
        endcase
        pos_d = pos_q + 9'd1;
      end
      PH_DATA: begin
        if (cnt_q < CntW'(BufferDepth)) begin
          res.event_res      = EV_PAYLOAD;
          res.payload_byte   = byte_i;
          res.payload_index  = cnt_ext[9:0];
          res.command_code   = acmd_q;
          res.message_length = alen_q;
          cnt_d  = cnt_q + CntW'(1);
          roff_d = roff_q + 16'd1;
          if (pos_q == {1'b0, flen_q}) begin
            phase_d = PH_END;
          end
          pos_d = pos_q + 9'd1;
        end else begin
          ok = 1'b0;
        end
      end
      PH_END: begin
        if (byte_i == END_BYTE) begin
          res.command_code   = acmd_q;
          res.message_length = alen_q;
          phase_d = PH_HUNT;
          pos_d   = '0;
          if (roff_q == alen_q) begin
            res.event_res = EV_DONE;
            alen_d = '0;
            roff_d = '0;
            cnt_d  = '0;
          end else begin
            res.event_res = EV_FRAGMENT;
          end
        end else begin
          ok = 1'b0;
        end
      end
      default: ok = 1'b0;
    endcase

    // any error drops the frame and the open message
    if (!ok) begin
      phase_d = PH_HUNT;
      pos_d   = '0;
      alen_d  = '0;
      roff_d  = '0;
      cnt_d   = '0;
      res     = '0;
      res.event_res = EV_ERROR;
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      pos_q     <= '0;
      flen_q    <= '0;
      hlen_hi_q <= '0;
      hlen_lo_q <= '0;
      hcmd_q    <= '0;
      hoff_hi_q <= '0;
      alen_q    <= '0;
      acmd_q    <= '0;
      roff_q    <= '0;
      cnt_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      flen_q    <= flen_d;
      hlen_hi_q <= hlen_hi_d;
      hlen_lo_q <= hlen_lo_d;
      hcmd_q    <= hcmd_d;
      hoff_hi_q <= hoff_hi_d;
      alen_q    <= alen_d;
      acmd_q    <= acmd_d;
      roff_q    <= roff_d;
      cnt_q     <= cnt_d;
    end
  end

  as_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("parse phase not one-hot");

  as_hunt_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HUNT) |-> (pos_q == 9'd0))
    else $error("frame position nonzero while hunting");

  as_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(BufferDepth))
    else $error("stored count beyond buffer depth");

  as_open_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA || phase_q == PH_END) |-> (alen_q != 16'd0))
    else $error("payload phase without open message");

endmodule

// ===== sv/fragmented_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// fragmented_frame_receiver_top
// Link byte parser that checks frame headers and reassembles fragments.
// ----------------------------------------------------------------------------
// Bytes of the link stream enter on the s_axis channel, one byte per request.
// Every byte gives exactly one result request on m_axis: an event code and,
// for payload bytes, the byte with its index in the reassembled message,
// plus the open message's command and message length (done, fragment too).
// The cfg channel writes the invalid command code; it is always ready and
// is meant to be written while no byte is in flight.
// A result passes through the input register and then the result register.
// Throughput: one byte per cycle while m_axis does not stall; the parse state
// is updated as a byte moves from the input register to the result register.
// When m_axis stalls, the result register holds and the input register
// takes one more byte, then s_axis_tready drops until the result is taken.
// Reset clears both valid flags, the parse state (back to hunting the start
// byte, no message open) and sets the invalid command code to zero.
// ----------------------------------------------------------------------------
module fragmented_frame_receiver_top #(
  parameter int unsigned BufferDepth = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // rx_byte
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // event_res[2:0], payload_byte[10:3], payload_index[20:11],
  // command_code[28:21], message_length[44:29], zero pad[47:45]
  output logic [ffr_pkg::ResultBytesW-1:0]   m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [7:0]                         cfg_data_i      // invalid_command_code
);
  import ffr_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  ffr_result_t out_q;
  ffr_result_t res;
  logic [7:0]  inv_cmd_q;
  logic        advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  ffr_parser #(
    .BufferDepth(BufferDepth)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (in_byte_q),
    .invalid_cmd_i(inv_cmd_q),
    .result_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_cmd_q <= '0;
    end else if (cfg_valid_i) begin
      inv_cmd_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ResultBytesW - ResultW){1'b0}}, out_q};

  as_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |-> (out_valid_q && !m_axis_tready))
    else $error("input byte held without output stall");

  as_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed byte gave no result");

  as_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.event_res == EV_ERROR) |->
      (out_q.command_code == 8'd0 && out_q.message_length == 16'd0))
    else $error("error result carries message fields");

  as_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.event_res == EV_PAYLOAD) |-> (out_q.message_length != 16'd0))
    else $error("payload byte without message length");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fragmented frame receiver.
// ----------------------------------------------------------------------------
// A short table of link bytes checks hunting, header rejects and a one-byte
// message. Random phases follow: mostly well-formed fragmented messages,
// some with a broken header or end byte, mixed with noise, random headers
// and one message long enough to overrun the reassembly buffer. Each phase
// uses its own invalid command code. Every accepted byte runs through a local
// parser model. Its result is queued and compared with the stream output.
// Before the last phase, sender idles in bursts and receiver stalls at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ffr_pkg::*;

  localparam int unsigned BUF_DEPTH      = 1024;
  localparam int unsigned MAX_FRAG       = 249;
  localparam int unsigned PHASE_ITEMS    = 48;
  localparam int unsigned NUM_PHASES     = 4;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DIR_ROWS       = 27;

  typedef enum int {
    FAULT_NONE,
    FAULT_ZERO_LEN,
    FAULT_BAD_CMD,
    FAULT_OFFSET,
    FAULT_LEN,
    FAULT_CMD,
    FAULT_OVERRUN,
    FAULT_SHORT,
    FAULT_END
  } fault_e;

  typedef struct {
    logic [7:0]  rx_byte;
    bit          pinned;
    ffr_result_t want;
  } link_req_t;

  typedef struct {
    logic [7:0] rx_byte;
    bit         pinned;
    ffr_event_e ev;
  } dir_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata;   // rx_byte
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  // event_res, payload_byte, payload_index, command_code, message_length, pad
  logic [ResultBytesW-1:0] m_axis_tdata;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [7:0]              cfg_data_i;     // invalid_command_code

  // parser model state
  logic [7:0]  cfg_bad_cmd;
  ffr_phase_e  rx_phase;
  logic [8:0]  fpos;
  logic [7:0]  flen;
  logic [15:0] hdr_mlen;
  logic [7:0]  hdr_cmd;
  logic [15:0] hdr_off;
  logic [15:0] msg_len;
  logic [7:0]  msg_cmd;
  logic [15:0] run_off;
  logic [10:0] buf_count;

  ffr_result_t expected_events[$];
  link_req_t   link_q[$];
  link_req_t   link_now;
  dir_row_t    directed_rows[DIR_ROWS];
  logic [7:0]  phase_bad_cmd;
  int          fail_count;
  bit          tx_gap_en;
  bit          rx_stall_en;
  int          stall_left = 0;

  fragmented_frame_receiver_top #(
    .BufferDepth(BUF_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void drop_frame();
    rx_phase = PH_HUNT;
    fpos     = '0;
    flen     = '0;
    hdr_mlen = '0;
    hdr_cmd  = cfg_bad_cmd;
    hdr_off  = '0;
  endfunction

  function automatic void drop_message();
    drop_frame();
    msg_len   = '0;
    msg_cmd   = cfg_bad_cmd;
    run_off   = '0;
    buf_count = '0;
  endfunction

  function automatic bit header_accepts();
    int plen;
    bit ok;
    if ({1'b0, flen} < PAYLOAD_POS) return 1'b0;
    plen = int'(flen) - int'(PAYLOAD_POS) + 1;
    ok = hdr_mlen != 16'd0 && hdr_cmd != cfg_bad_cmd
         && int'(hdr_off) + plen <= int'(hdr_mlen);
    // a continuing fragment must line up with the open message
    if (msg_len != 16'd0) begin
      ok = ok && msg_len == hdr_mlen && msg_cmd == hdr_cmd && run_off == hdr_off;
    end else if (ok) begin
      msg_len = hdr_mlen;
      msg_cmd = hdr_cmd;
    end
    return ok;
  endfunction

  function automatic ffr_result_t parse_link_byte(input logic [7:0] b);
    ffr_result_t r;
    bit ok;
    r = '0;
    r.event_res = EV_CONSUMED;
    ok = 1'b1;
    case (rx_phase)
      PH_HUNT: begin
        if (fpos == 9'd0 && b == START_BYTE) begin
          rx_phase = PH_HEADER;
          fpos = POS_FLEN;
        end else begin
          r.event_res = EV_IGNORED;
        end
      end
      PH_HEADER: begin
        case (fpos)
          POS_FLEN:    flen = b;
          POS_MLEN_HI: hdr_mlen |= {b, 8'h00};
          POS_MLEN_LO: hdr_mlen |= {8'h00, b};
          POS_CMD:     hdr_cmd = b;
          POS_OFF_HI:  hdr_off |= {b, 8'h00};
          POS_OFF_LO: begin
            hdr_off |= {8'h00, b};
            if (header_accepts()) rx_phase = PH_DATA;
            else ok = 1'b0;
          end
          default: ok = 1'b0;
        endcase
        if (ok) fpos = fpos + 9'd1;
      end
      PH_DATA: begin
        if (buf_count < BUF_DEPTH) begin
          r.event_res      = EV_PAYLOAD;
          r.payload_byte   = b;
          r.payload_index  = buf_count[9:0];
          r.command_code   = msg_cmd;
          r.message_length = msg_len;
          buf_count = buf_count + 11'd1;
          run_off   = run_off + 16'd1;
          if (fpos == {1'b0, flen}) rx_phase = PH_END;
          fpos = fpos + 9'd1;
        end else begin
          ok = 1'b0;
        end
      end
      default: begin
        if (fpos == {1'b0, flen} + 9'd1 && b == END_BYTE) begin
          r.command_code   = msg_cmd;
          r.message_length = msg_len;
          if (run_off == msg_len) begin
            r.event_res = EV_DONE;
            drop_message();
          end else begin
            r.event_res = EV_FRAGMENT;
            drop_frame();
          end
        end else begin
          ok = 1'b0;
        end
      end
    endcase
    if (!ok) begin
      drop_message();
      r = '0;
      r.event_res = EV_ERROR;
    end
    return r;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // output check first, then queue the prediction for a byte taken at this edge
  always @(posedge clk_i) begin : scoreboard
    ffr_result_t got;
    ffr_result_t want;
    ffr_result_t predicted;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = ffr_result_t'(m_axis_tdata[ResultW-1:0]);
        if (expected_events.size() == 0) begin
          $error("result with no byte waiting: event_res %0d", got.event_res);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          compare_field("event_res", want.event_res, got.event_res);
          compare_field("payload_byte", want.payload_byte, got.payload_byte);
          compare_field("payload_index", want.payload_index, got.payload_index);
          compare_field("command_code", want.command_code, got.command_code);
          compare_field("message_length", want.message_length, got.message_length);
        end
      end
      if (cfg_valid_i && cfg_ready_o) cfg_bad_cmd = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = parse_link_byte(s_axis_tdata);
        expected_events.insert(expected_events.size(),
                               link_now.pinned ? link_now.want : predicted);
      end
    end
  end

  // receiver: random stalls
  always @(negedge clk_i) begin
    if (!rx_stall_en) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 6);
    end
  end

  task automatic push_link_byte(input logic [7:0] b);
    link_req_t req;
    req.rx_byte = b;
    req.pinned  = 1'b0;
    req.want    = '0;
    link_q.insert(link_q.size(), req);
  endtask

  task automatic queue_frame(input logic [7:0] fl, input logic [15:0] ml,
                             input logic [7:0] cmd, input logic [15:0] off,
                             input logic [7:0] end_b);
    push_link_byte(START_BYTE);
    push_link_byte(fl);
    push_link_byte(ml[15:8]);
    push_link_byte(ml[7:0]);
    push_link_byte(cmd);
    push_link_byte(off[15:8]);
    push_link_byte(off[7:0]);
    if ({1'b0, fl} >= PAYLOAD_POS) begin
      repeat (int'(fl) - 6) push_link_byte(8'($urandom_range(0, 255)));
      push_link_byte(end_b);
    end
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 8)) push_link_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic add_random_header();
    push_link_byte(START_BYTE);
    repeat (6) push_link_byte(8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 12)) push_link_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic add_message(input bit long_run);
    int         total;
    int         off;
    int         plen;
    int         frags;
    int         frag_cap;
    int         max_frag;
    fault_e     fault;
    logic [7:0] cmd;
    logic [7:0] fl;
    logic [15:0] h_mlen;
    logic [7:0] h_cmd;
    logic [15:0] h_off;
    logic [7:0] end_b;
    logic [7:0] gap_b;
    frag_cap = 6;
    if (long_run) begin
      total = 1030;
      max_frag = MAX_FRAG;
      frag_cap = 100;
    end else if ($urandom_range(0, 7) == 0) begin
      // random length up to 65535, sent as at most two fragments, so often left open
      total = $urandom_range(1, 65535);
      max_frag = MAX_FRAG;
      frag_cap = 2;
    end else begin
      total = $urandom_range(1, 60);
      max_frag = ($urandom_range(0, 5) == 0) ? MAX_FRAG : 16;
    end
    do cmd = 8'($urandom_range(0, 255)); while (cmd == phase_bad_cmd);
    off = 0;
    frags = 0;
    while (off < total && frags < frag_cap) begin
      plen = long_run ? max_frag : $urandom_range(1, max_frag);
      if (plen > total - off) plen = total - off;
      fl     = 8'(plen + 6);
      h_mlen = 16'(total);
      h_cmd  = cmd;
      h_off  = 16'(off);
      end_b  = END_BYTE;
      fault  = FAULT_NONE;
      if (!long_run && $urandom_range(0, 9) == 0) fault = fault_e'($urandom_range(1, 8));
      case (fault)
        FAULT_ZERO_LEN: h_mlen = 16'd0;
        FAULT_BAD_CMD:  h_cmd = phase_bad_cmd;
        FAULT_OFFSET:   h_off = 16'(off + $urandom_range(1, 255));
        FAULT_LEN:      h_mlen = h_mlen ^ 16'(1 << $urandom_range(0, 15));
        FAULT_CMD:      h_cmd = cmd ^ 8'(1 << $urandom_range(0, 7));
        FAULT_OVERRUN: begin
          if (total - off + 1 <= int'(MAX_FRAG)) fl = 8'(total - off + 7);
          else h_off = 16'(total);
        end
        FAULT_SHORT:    fl = 8'($urandom_range(0, 6));
        FAULT_END: begin
          do end_b = 8'($urandom_range(0, 255)); while (end_b == END_BYTE);
        end
        default: ;
      endcase
      queue_frame(fl, h_mlen, h_cmd, h_off, end_b);
      if (fault != FAULT_NONE) return;
      off += plen;
      frags++;
      // bytes between fragments are ignored while hunting
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          do gap_b = 8'($urandom_range(0, 255)); while (gap_b == START_BYTE);
          push_link_byte(gap_b);
        end
      end
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_link(input int drain_at);
    int burst_left;
    int gap;
    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < link_q.size(); i++) begin
      if (i == drain_at) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
        while (expected_events.size() != 0) @(negedge clk_i);
      end else if (tx_gap_en && burst_left <= 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      link_now = link_q[i];
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= link_q[i].rx_byte;
      do @(posedge clk_i); while (!s_axis_tready);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
    link_q.delete();
  endtask

  task automatic settle();
    while (expected_events.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_bad_cmd(input logic [7:0] code);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= code;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    phase_bad_cmd = code;
  endtask

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main
    link_req_t  req;
    logic [7:0] code;
    int         pick;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 8'h00;
    fail_count    = 0;
    phase_bad_cmd = 8'h00;
    tx_gap_en     = 1'b1;
    rx_stall_en   = 1'b1;
    cfg_bad_cmd   = 8'h00;
    drop_message();

    directed_rows = '{
      '{8'h00, 1'b1, EV_IGNORED},
      '{8'hFF, 1'b1, EV_IGNORED},
      '{END_BYTE, 1'b1, EV_IGNORED},
      // frame length six is too short
      '{START_BYTE, 1'b1, EV_CONSUMED},
      '{8'h06, 1'b1, EV_CONSUMED},
      '{8'h00, 1'b1, EV_CONSUMED},
      '{8'h01, 1'b1, EV_CONSUMED},
      '{8'h10, 1'b1, EV_CONSUMED},
      '{8'h00, 1'b1, EV_CONSUMED},
      '{8'h00, 1'b1, EV_ERROR},
      // one-byte message, command 0xff
      '{START_BYTE, 1'b1, EV_CONSUMED},
      '{8'h07, 1'b1, EV_CONSUMED},
      '{8'h00, 1'b1, EV_CONSUMED},
      '{8'h01, 1'b1, EV_CONSUMED},
      '{8'hFF, 1'b1, EV_CONSUMED},
      '{8'h00, 1'b1, EV_CONSUMED},
      '{8'h00, 1'b1, EV_CONSUMED},
      '{8'hA5, 1'b0, EV_PAYLOAD},
      '{END_BYTE, 1'b0, EV_DONE},
      // command zero is the invalid code after reset
      '{START_BYTE, 1'b1, EV_CONSUMED},
      '{8'h07, 1'b1, EV_CONSUMED},
      '{8'h00, 1'b1, EV_CONSUMED},
      '{8'h01, 1'b1, EV_CONSUMED},
      '{8'h00, 1'b1, EV_CONSUMED},
      '{8'h00, 1'b1, EV_CONSUMED},
      '{8'h00, 1'b1, EV_ERROR},
      '{8'h55, 1'b1, EV_IGNORED}
    };

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      req.rx_byte = directed_rows[i].rx_byte;
      req.pinned  = directed_rows[i].pinned;
      req.want    = '0;
      req.want.event_res = directed_rows[i].ev;
      link_q.insert(link_q.size(), req);
    end
    send_link(-1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       code = 8'hFF;
        1:       code = 8'($urandom_range(1, 254));
        2:       code = 8'h00;
        default: code = 8'($urandom_range(0, 255));
      endcase
      write_bad_cmd(code);
      tx_gap_en = (p != 3);
      rx_stall_en <= (p != 3);
      if (p == 2) begin
        // start the buffer overrun from a clean parser with no open message
        if (rx_phase != PH_HUNT) repeat (256) push_link_byte(8'h00);
        push_link_byte(START_BYTE);
        repeat (6) push_link_byte(8'h00);
        add_message(1'b1);
      end
      while (link_q.size() < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) add_message(1'b0);
        else if (pick < 8) add_random_header();
        else add_noise();
      end
      send_link(p == 1 ? int'(PHASE_ITEMS / 2) : -1);
    end

    settle();
    if (fail_count == 0 && expected_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
